// ===== rtl/wfo_pkg.sv =====
// ----------------------------------------------------------------------------
// wfo_pkg
// Types, codes and constants shared by the wavetable FM oscillator modules.
// ----------------------------------------------------------------------------
package wfo_pkg;

    // Default build parameters: table of 2**10 entries, 16 phase fraction bits.
    localparam int DEF_TABLE_ADDR_W    = 10;
    localparam int DEF_PHASE_FRAC_BITS = 16;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 26;
    localparam int AMP_W    = 16;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    localparam logic [STEP_W-1:0] STEP_RESET = 26'd65536;
    localparam logic [AMP_W-1:0]  AMP_ONE    = 16'd32768;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_LEVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OSC_MODE   = 2'd2;

    // Oscillator mode codes.
    localparam logic [MODE_W-1:0] MODE_MOD_PLAIN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MOD_FM    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CAR_PLAIN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CAR_FM    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUM       = 3'd4;

    // Operation class assigned to each item by the front end.
    typedef enum logic [1:0] {
        OP_PLAIN = 2'd0,
        OP_FM    = 2'd1,
        OP_SUM   = 2'd2,
        OP_HOLD  = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_last_out;
    } t_out_item;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [AMP_W-1:0]  amp_level;
        logic [MODE_W-1:0] osc_mode;
    } t_cfg;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/wavetable_fm_oscillator_core.sv =====
// ----------------------------------------------------------------------------
// wavetable_fm_oscillator_core
// Sine wavetable oscillator with plain, FM, and sum modes on Q1.15 samples.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   out       source     o_out_valid / i_out_stall o_out_data (t_out_item)
//   cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The back end sequencer steps each item through the table read and
// registered multiplies, then the output register; sum mode adds further
// multiplies. The next table read waits for the phase update.
// Reset is synchronous; the sine table is a constant ROM and needs no fill.
// The two-entry queue takes input items while the back end or the output
// is stalled; the finished item waits in the output register.
// ----------------------------------------------------------------------------
module wavetable_fm_oscillator_core #(
    parameter int TABLE_ADDR_W    = wfo_pkg::DEF_TABLE_ADDR_W,
    parameter int PHASE_FRAC_BITS = wfo_pkg::DEF_PHASE_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  wfo_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output wfo_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wfo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wfo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    wfo_pkg::t_cfg      r_cfg;
    wfo_pkg::t_q_status q_status;
    wfo_pkg::t_job      push_job;
    wfo_pkg::t_job      pop_job;
    logic               push;
    logic               pop;
    logic               cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Amplitude writes above one are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step <= wfo_pkg::STEP_RESET;
            r_cfg.amp_level  <= wfo_pkg::AMP_ONE;
            r_cfg.osc_mode   <= wfo_pkg::MODE_MOD_PLAIN;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                wfo_pkg::CFG_PHASE_STEP: begin
                    r_cfg.phase_step <= i_cfg_data[wfo_pkg::STEP_W-1:0];
                end
                wfo_pkg::CFG_AMP_LEVEL: begin
                    if (i_cfg_data[wfo_pkg::AMP_W-1:0] <= wfo_pkg::AMP_ONE) begin
                        r_cfg.amp_level <= i_cfg_data[wfo_pkg::AMP_W-1:0];
                    end
                end
                wfo_pkg::CFG_OSC_MODE: begin
                    r_cfg.osc_mode <= i_cfg_data[wfo_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    wfo_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_osc_mode (r_cfg.osc_mode),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    wfo_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_status (q_status)
    );

    wfo_back #(
        .TABLE_ADDR_W    (TABLE_ADDR_W),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/wfo_front.sv =====
// ----------------------------------------------------------------------------
// wfo_front
// Input side: takes items while the queue has room and tags each with the
// operation class that the current mode selects.
// ----------------------------------------------------------------------------
module wfo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wfo_pkg::t_in_item  i_in_data,
    input  logic [wfo_pkg::MODE_W-1:0] i_osc_mode,
    input  wfo_pkg::t_q_status i_q_status,
    output logic               o_push,
    output wfo_pkg::t_job      o_job
);

    wfo_pkg::t_op op_class;

    always_comb begin
        unique case (i_osc_mode) inside
            wfo_pkg::MODE_MOD_PLAIN, wfo_pkg::MODE_CAR_PLAIN: op_class = wfo_pkg::OP_PLAIN;
            wfo_pkg::MODE_MOD_FM, wfo_pkg::MODE_CAR_FM:       op_class = wfo_pkg::OP_FM;
            wfo_pkg::MODE_SUM:                                op_class = wfo_pkg::OP_SUM;
            default:                                          op_class = wfo_pkg::OP_HOLD;
        endcase
    end

    assign o_in_stall   = i_q_status.full;
    assign o_push       = i_in_valid && !i_q_status.full;
    assign o_job.op     = op_class;
    assign o_job.sample = i_in_data.sample_in;
    assign o_job.last   = i_in_data.block_last_in;

    // Nothing may be pushed into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.full |-> !o_push)
        else $error("item pushed into full queue");

endmodule

// ===== rtl/wfo_queue.sv =====
// ----------------------------------------------------------------------------
// wfo_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module wfo_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wfo_pkg::t_job      i_job,
    input  logic               i_pop,
    output wfo_pkg::t_job      o_job,
    output wfo_pkg::t_q_status o_status
);

    localparam int DEPTH = 2;

    wfo_pkg::t_job r_mem [DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != 2'd0);
    assign o_status.full  = (r_count == 2'(DEPTH));

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty queue");

endmodule

// ===== rtl/wfo_back.sv =====
// ----------------------------------------------------------------------------
// wfo_back
// Execution side: reads the sine table at the current phase, forms the
// output through a chain of registered multiplies, advances the phase
// except in invalid modes and holds the result in the output register.
// ----------------------------------------------------------------------------
module wfo_back #(
    parameter int TABLE_ADDR_W    = wfo_pkg::DEF_TABLE_ADDR_W,
    parameter int PHASE_FRAC_BITS = wfo_pkg::DEF_PHASE_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wfo_pkg::t_cfg      i_cfg,
    input  wfo_pkg::t_q_status i_q_status,
    input  wfo_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wfo_pkg::t_out_item o_out_data
);

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_W;
    localparam int ACC_W      = TABLE_ADDR_W + PHASE_FRAC_BITS;
    localparam int INC_W      = wfo_pkg::STEP_W + 1;
    localparam int PSUM_W     = ((ACC_W > INC_W) ? ACC_W : INC_W) + 1;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ROUND_Q30   = 64'd1 << 29;
    localparam logic [63:0] TAYLOR_D1   = 64'd6;
    localparam logic [63:0] TAYLOR_D2   = 64'd20;
    localparam logic [63:0] TAYLOR_D3   = 64'd42;
    localparam logic [63:0] TAYLOR_D4   = 64'd72;
    localparam logic [63:0] TAYLOR_D5   = 64'd110;
    localparam logic [63:0] TAYLOR_D6   = 64'd156;
    localparam logic [63:0] TAYLOR_D7   = 64'd210;

    typedef logic signed [wfo_pkg::SAMPLE_W-1:0] t_rom [TABLE_SIZE];

    // One table entry, from a Q30 Taylor series of sin over a quarter turn.
    function automatic logic signed [15:0] sine_entry(input logic [31:0] idx);
        logic [63:0]        turn;
        logic [63:0]        quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] val;
        turn = 64'(idx) << (32 - TABLE_ADDR_W);
        quad = (turn >> 30) & 64'd3;
        r    = turn & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        sum  = signed'(x);
        term = ((x * x2) >> 30) / TAYLOR_D1;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / TAYLOR_D2;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / TAYLOR_D3;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / TAYLOR_D4;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / TAYLOR_D5;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / TAYLOR_D6;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / TAYLOR_D7;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > signed'(Q30_ONE)) begin
            sum = signed'(Q30_ONE);
        end
        val = signed'((unsigned'(sum) * 64'd32767 + ROUND_Q30) >> 30);
        if (val > 64'sd32767) begin
            val = 64'sd32767;
        end
        if (quad >= 64'd2) begin
            val = -val;
        end
        return val[15:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = sine_entry(32'(i));
        end
        return rom;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
        logic signed [15:0] res;
        if (v > 23'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -23'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_MIX  = 6'b000100,
        S_MUL2 = 6'b001000,
        S_MUL3 = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [ACC_W-1:0]            r_phase;
    wfo_pkg::t_op                r_op;
    logic signed [15:0]          r_x;
    logic                        r_last;
    logic signed [15:0]          r_rom_q;
    logic signed [32:0]          r_pa;
    logic signed [32:0]          r_pb;
    logic [INC_W-1:0]            r_inc;
    logic signed [17:0]          r_mix;
    logic signed [17:0]          r_plain;
    logic signed [34:0]          r_pc;
    logic signed [38:0]          r_pd;
    logic                        r_out_valid;
    wfo_pkg::t_out_item          r_out;

    logic signed [16:0]          amp_s;
    logic signed [16:0]          inv_amp;
    logic [15:0]                 x_offset;
    logic [41:0]                 fm_prod;
    logic signed [33:0]          mix_sum;
    logic signed [20:0]          sum_s;
    logic signed [17:0]          sum_scale;
    logic [PSUM_W-1:0]           phase_sum;
    logic signed [22:0]          res_wide;
    logic                        slot_free;

    assign amp_s     = signed'({1'b0, i_cfg.amp_level});
    assign inv_amp   = 17'sd32768 - amp_s;
    // 32768 + x as an unsigned value is x with its sign bit flipped.
    assign x_offset  = {!r_x[15], r_x[14:0]};
    assign fm_prod   = 42'(x_offset) * 42'(i_cfg.phase_step);
    assign mix_sum   = 34'(r_pa) + 34'(r_pb);
    assign sum_s     = 21'(signed'(r_pc[34:15])) + 21'(r_x);
    assign sum_scale = 18'sd65536 - 18'(amp_s);
    assign phase_sum = PSUM_W'(r_phase) + PSUM_W'(r_inc);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && i_q_status.valid;

    always_comb begin
        case (r_op)
            wfo_pkg::OP_PLAIN: res_wide = 23'(r_plain);
            wfo_pkg::OP_SUM:   res_wide = r_pd[38:16];
            default:           res_wide = 23'(r_mix);
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_status.valid) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MIX;
            S_MIX: begin
                n_state = (r_op == wfo_pkg::OP_SUM) ? S_MUL2 : S_OUT;
            end
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_OUT;
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= i_job.op;
            r_x     <= i_job.sample;
            r_last  <= i_job.last;
            r_rom_q <= SINE_ROM[r_phase[ACC_W-1 -: TABLE_ADDR_W]];
        end
        if (r_state == S_MUL1) begin
            r_pa  <= 33'(inv_amp) * 33'(r_x);
            r_pb  <= 33'(r_rom_q) * 33'(amp_s);
            r_inc <= (r_op == wfo_pkg::OP_FM) ? fm_prod[41:15]
                                              : INC_W'(i_cfg.phase_step);
        end
        if (r_state == S_MIX) begin
            r_mix   <= mix_sum[32:15];
            r_plain <= r_pb[32:15];
        end
        if (r_state == S_MUL2) begin
            r_pc <= 35'(amp_s) * 35'(r_mix);
        end
        if (r_state == S_MUL3) begin
            r_pd <= 39'(sum_s) * 39'(sum_scale);
        end
        if (r_state == S_OUT && slot_free) begin
            r_out.sample_out     <= sat16(res_wide);
            r_out.block_last_out <= r_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MIX && r_op != wfo_pkg::OP_HOLD) begin
                r_phase <= phase_sum[ACC_W-1:0];
            end
            if (r_state == S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL1))
        else $error("pop did not start an item");

    a_hold_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX && r_op == wfo_pkg::OP_HOLD) |=> $stable(r_phase))
        else $error("phase moved in invalid mode");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && slot_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished item not placed in output register");

    a_phase_only_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MIX) |=> $stable(r_phase))
        else $error("phase changed outside update step");

endmodule
